>>> sv/pmr_pkg.sv
// Package for the pose matrix to position and rotation vector block.
// Holds fixed-point constants, stage counts and the arctangent table.
// No dependencies.
package pmr_pkg;

    // Q16.16 constants.
    localparam int Q_ONE     = 65536;
    localparam int HALF_PI_Q = 102944;
    localparam int PI_Q      = 205887;

    // Field widths.
    localparam int ROT_W   = 18;
    localparam int TRANS_W = 32;
    localparam int OUT_W   = 32;
    localparam int LIMIT_W = 18;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'd66;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Internal widths.
    localparam int COS_W   = 18;   // clamped cosine, signed
    localparam int DIFF_W  = 19;   // skew difference, signed
    localparam int MAG_W   = 18;   // magnitude of a skew difference
    localparam int RAD_W   = 33;   // 2^32 - c*c
    localparam int SIN_W   = 17;   // floor square root
    localparam int ANG_W   = 18;   // clamped angle, unsigned
    localparam int NUM_W   = 36;   // angle times magnitude
    localparam int DEN_W   = 18;   // twice the sine

    // Iteration counts.
    localparam int SQRT_STEPS    = 17;
    localparam int CORDIC_STEPS  = 17;
    localparam int CORDIC_SHIFT  = 14;
    localparam int CORDIC_W      = 34;
    localparam int ANGLE_ACC_W   = 20;
    localparam int DIV_STEPS     = NUM_W;
    localparam int LANES         = 3;

    // atan(2^-i) in Q16.16, rounded to nearest.
    localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
        17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16,
        17'd8, 17'd4, 17'd2, 17'd1
    };

endpackage

>>> sv/pmr_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word alongside each operand. Depends on pmr_pkg.
module pmr_isqrt
    import pmr_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [SIN_W-1:0]  out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int PAD_W = 2 * SQRT_STEPS;
    localparam int REM_W = SIN_W + 1;

    logic              vld_reg  [SQRT_STEPS];
    logic [PAD_W-1:0]  rad_reg  [SQRT_STEPS];
    logic [REM_W-1:0]  rem_reg  [SQRT_STEPS];
    logic [SIN_W-1:0]  root_reg [SQRT_STEPS];
    logic [SIDE_W-1:0] side_reg [SQRT_STEPS];

    logic [PAD_W-1:0]  rad_next  [SQRT_STEPS];
    logic [REM_W-1:0]  rem_next  [SQRT_STEPS];
    logic [SIN_W-1:0]  root_next [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        logic              src_vld;
        logic [PAD_W-1:0]  src_rad;
        logic [REM_W-1:0]  src_rem;
        logic [SIN_W-1:0]  src_root;
        logic [SIDE_W-1:0] src_side;
        logic [REM_W+1:0]  trial_val;
        logic [REM_W+1:0]  part_val;
        logic [REM_W+1:0]  diff_val;
        logic              fits;

        if (j == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_rad  = PAD_W'(in_rad);
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_side = in_side;
        end
        else begin : g_rest
            assign src_vld  = vld_reg[j-1];
            assign src_rad  = rad_reg[j-1];
            assign src_rem  = rem_reg[j-1];
            assign src_root = root_reg[j-1];
            assign src_side = side_reg[j-1];
        end

        // Bring down the next pair of radicand bits and try a one.
        assign part_val  = {src_rem, src_rad[PAD_W-1:PAD_W-2]};
        assign trial_val = {1'b0, src_root, 2'b01};
        assign fits      = part_val >= trial_val;
        assign diff_val  = part_val - trial_val;

        assign rem_next[j]  = fits ? diff_val[REM_W-1:0] : part_val[REM_W-1:0];
        assign root_next[j] = {src_root[SIN_W-2:0], fits};
        assign rad_next[j]  = {src_rad[PAD_W-3:0], 2'b00};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[j]  <= rad_next[j];
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                side_reg[j] <= src_side;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

>>> sv/pmr_cordic.sv
// Pipelined CORDIC in vectoring mode, one rotation per register stage.
// Gives the clamped angle of (c, s). Depends on pmr_pkg.
module pmr_cordic
    import pmr_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [COS_W-1:0] in_cos,
    input  logic [SIN_W-1:0]        in_sin,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic [ANG_W-1:0]        out_angle,
    output logic [SIDE_W-1:0]       out_side
);

    logic                          vld_reg  [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0]    x_reg    [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0]    y_reg    [CORDIC_STEPS];
    logic signed [ANGLE_ACC_W-1:0] z_reg    [CORDIC_STEPS];
    logic [SIDE_W-1:0]             side_reg [CORDIC_STEPS];

    logic signed [CORDIC_W-1:0]    x_next [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0]    y_next [CORDIC_STEPS];
    logic signed [ANGLE_ACC_W-1:0] z_next [CORDIC_STEPS];

    logic signed [CORDIC_W-1:0]    cos_sh;
    logic signed [CORDIC_W-1:0]    sin_sh;
    logic signed [CORDIC_W-1:0]    x_init;
    logic signed [CORDIC_W-1:0]    y_init;
    logic signed [ANGLE_ACC_W-1:0] z_init;
    logic signed [ANGLE_ACC_W-1:0] z_last;

    // A negative cosine is turned by a quarter so the loop converges.
    assign cos_sh = CORDIC_W'(in_cos) <<< CORDIC_SHIFT;
    assign sin_sh = $signed(CORDIC_W'(in_sin)) <<< CORDIC_SHIFT;
    assign x_init = (in_cos < 0) ? sin_sh : cos_sh;
    assign y_init = (in_cos < 0) ? -cos_sh : sin_sh;
    assign z_init = (in_cos < 0) ? ANGLE_ACC_W'(HALF_PI_Q) : '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic                          src_vld;
        logic signed [CORDIC_W-1:0]    src_x;
        logic signed [CORDIC_W-1:0]    src_y;
        logic signed [ANGLE_ACC_W-1:0] src_z;
        logic [SIDE_W-1:0]             src_side;
        logic signed [ANGLE_ACC_W-1:0] step_ang;

        if (i == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_x    = x_init;
            assign src_y    = y_init;
            assign src_z    = z_init;
            assign src_side = in_side;
        end
        else begin : g_rest
            assign src_vld  = vld_reg[i-1];
            assign src_x    = x_reg[i-1];
            assign src_y    = y_reg[i-1];
            assign src_z    = z_reg[i-1];
            assign src_side = side_reg[i-1];
        end

        assign step_ang = $signed(ANGLE_ACC_W'(ATAN_TAB[i]));

        always_comb
        begin
            if (src_y > 0)
            begin
                x_next[i] = src_x + (src_y >>> i);
                y_next[i] = src_y - (src_x >>> i);
                z_next[i] = src_z + step_ang;
            end
            else
            begin
                x_next[i] = src_x - (src_y >>> i);
                y_next[i] = src_y + (src_x >>> i);
                z_next[i] = src_z - step_ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
                side_reg[i] <= src_side;
            end
        end
    end

    assign z_last = z_reg[CORDIC_STEPS-1];

    always_comb
    begin
        if (z_last < 0)
        begin
            out_angle = '0;
        end
        else if (z_last > ANGLE_ACC_W'(PI_Q))
        begin
            out_angle = ANG_W'(PI_Q);
        end
        else
        begin
            out_angle = z_last[ANG_W-1:0];
        end
    end

    assign out_valid = vld_reg[CORDIC_STEPS-1];
    assign out_side  = side_reg[CORDIC_STEPS-1];

endmodule

>>> sv/pmr_div.sv
// Pipelined restoring divider, three lanes sharing one divisor.
// One quotient bit per register stage. Depends on pmr_pkg.
module pmr_div
    import pmr_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0]            in_den,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][NUM_W-1:0] out_quot,
    output logic [SIDE_W-1:0]           out_side
);

    logic                        vld_reg  [DIV_STEPS];
    logic [LANES-1:0][NUM_W-1:0] nq_reg   [DIV_STEPS];
    logic [LANES-1:0][DEN_W-1:0] rem_reg  [DIV_STEPS];
    logic [DEN_W-1:0]            den_reg  [DIV_STEPS];
    logic [SIDE_W-1:0]           side_reg [DIV_STEPS];

    logic [LANES-1:0][NUM_W-1:0] nq_next  [DIV_STEPS];
    logic [LANES-1:0][DEN_W-1:0] rem_next [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic                        src_vld;
        logic [LANES-1:0][NUM_W-1:0] src_nq;
        logic [LANES-1:0][DEN_W-1:0] src_rem;
        logic [DEN_W-1:0]            src_den;
        logic [SIDE_W-1:0]           src_side;

        if (k == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_nq   = in_num;
            assign src_rem  = '0;
            assign src_den  = in_den;
            assign src_side = in_side;
        end
        else begin : g_rest
            assign src_vld  = vld_reg[k-1];
            assign src_nq   = nq_reg[k-1];
            assign src_rem  = rem_reg[k-1];
            assign src_den  = den_reg[k-1];
            assign src_side = side_reg[k-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W:0] part_val;
            logic [DEN_W:0] diff_val;
            logic           fits;

            // The dividend shifts out at the top while quotient bits enter below.
            assign part_val = {src_rem[l], src_nq[l][NUM_W-1]};
            assign fits     = part_val >= {1'b0, src_den};
            assign diff_val = part_val - {1'b0, src_den};

            assign rem_next[k][l] = fits ? diff_val[DEN_W-1:0] : part_val[DEN_W-1:0];
            assign nq_next[k][l]  = {src_nq[l][NUM_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[k]   <= nq_next[k];
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= src_den;
                side_reg[k] <= src_side;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_quot  = nq_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

>>> sv/pose_matrix_to_position_rotvec.sv
// Top level: homogeneous pose to position and rotation vector (log map).
// Uses pmr_pkg, pmr_isqrt, pmr_cordic and pmr_div.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-------------------------------------
//   pose    | pose_valid  | pose_stall  | rot_00 .. rot_22, trans_x/y/z
//   vec     | vec_valid   | vec_stall   | pos_x/y/z, rvec_x/y/z, small_angle
//   config  | psel/penable/pwrite, pready always high | small_angle_limit
//
// One word enters and one leaves per cycle while vec_stall does not hold the
// output word; each word passes stages A, B, E and F and the output register.
// The depth is set by the square root and CORDIC stages (one bit or rotation
// each) and by the divider, which resolves one quotient bit per stage.
// Reset clears every valid bit and loads the limit with 66 (about 0.001 rad).
// When the output word is held by vec_stall, the whole pipeline freezes and
// pose_stall is raised in the same cycle, so nothing is lost or repeated.
module pose_matrix_to_position_rotvec
    import pmr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      pose_valid,
    output logic                      pose_stall,
    input  logic signed [ROT_W-1:0]   rot_00,
    input  logic signed [ROT_W-1:0]   rot_01,
    input  logic signed [ROT_W-1:0]   rot_02,
    input  logic signed [ROT_W-1:0]   rot_10,
    input  logic signed [ROT_W-1:0]   rot_11,
    input  logic signed [ROT_W-1:0]   rot_12,
    input  logic signed [ROT_W-1:0]   rot_20,
    input  logic signed [ROT_W-1:0]   rot_21,
    input  logic signed [ROT_W-1:0]   rot_22,
    input  logic signed [TRANS_W-1:0] trans_x,
    input  logic signed [TRANS_W-1:0] trans_y,
    input  logic signed [TRANS_W-1:0] trans_z,

    output logic                      vec_valid,
    input  logic                      vec_stall,
    output logic signed [OUT_W-1:0]   pos_x,
    output logic signed [OUT_W-1:0]   pos_y,
    output logic signed [OUT_W-1:0]   pos_z,
    output logic signed [OUT_W-1:0]   rvec_x,
    output logic signed [OUT_W-1:0]   rvec_y,
    output logic signed [OUT_W-1:0]   rvec_z,
    output logic                      small_angle,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready
);

    // Sideband words that ride along the arithmetic units.
    typedef struct packed {
        logic signed [COS_W-1:0]             cos_v;
        logic [LANES-1:0][DIFF_W-1:0]        diff;
        logic [LANES-1:0][TRANS_W-1:0]       trans;
    } sq_side_t;

    typedef struct packed {
        logic [SIN_W-1:0]                    sin_v;
        logic [LANES-1:0][DIFF_W-1:0]        diff;
        logic [LANES-1:0][TRANS_W-1:0]       trans;
    } cd_side_t;

    typedef struct packed {
        logic                                small_v;
        logic                                sin_zero;
        logic [LANES-1:0]                    neg;
        logic [LANES-1:0]                    zero;
        logic [LANES-1:0][TRANS_W-1:0]       trans;
    } dv_side_t;

    localparam int SQ_SIDE_W = $bits(sq_side_t);
    localparam int CD_SIDE_W = $bits(cd_side_t);
    localparam int DV_SIDE_W = $bits(dv_side_t);

    logic en;

    // ---------------------------------------------------------------
    // Configuration register.
    // ---------------------------------------------------------------
    logic [LIMIT_W-1:0] limit_reg;
    logic               limit_hit;

    assign pready    = 1'b1;
    assign limit_hit = (paddr[APB_ADDR_W-1] == 1'b0);
    assign prdata    = limit_hit ? APB_DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && limit_hit)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // The whole pipeline advances unless the output word is held.
    assign en         = !(vec_valid && vec_stall);
    assign pose_stall = !en;

    // ---------------------------------------------------------------
    // Stage A: trace, clamped cosine and skew differences.
    // ---------------------------------------------------------------
    logic signed [19:0]      trace;
    logic signed [20:0]      trace_m1;
    logic signed [19:0]      cos_raw;
    logic signed [COS_W-1:0] cos_next;
    logic [LANES-1:0][DIFF_W-1:0] diff_next;

    assign trace    = 20'(rot_00) + 20'(rot_11) + 20'(rot_22);
    assign trace_m1 = 21'(trace) - 21'(Q_ONE);
    assign cos_raw  = trace_m1[20:1];

    always_comb
    begin
        if (cos_raw > 20'(Q_ONE))
        begin
            cos_next = COS_W'(Q_ONE);
        end
        else if (cos_raw < -20'(Q_ONE))
        begin
            cos_next = -COS_W'(Q_ONE);
        end
        else
        begin
            cos_next = cos_raw[COS_W-1:0];
        end
    end

    assign diff_next[0] = DIFF_W'(rot_21) - DIFF_W'(rot_12);
    assign diff_next[1] = DIFF_W'(rot_02) - DIFF_W'(rot_20);
    assign diff_next[2] = DIFF_W'(rot_10) - DIFF_W'(rot_01);

    logic                          a_vld_reg;
    logic signed [COS_W-1:0]       a_cos_reg;
    logic [LANES-1:0][DIFF_W-1:0]  a_diff_reg;
    logic [LANES-1:0][TRANS_W-1:0] a_trans_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= pose_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_cos_reg   <= cos_next;
            a_diff_reg  <= diff_next;
            a_trans_reg <= {trans_z, trans_y, trans_x};
        end
    end

    // ---------------------------------------------------------------
    // Stage B: radicand 2^32 - c^2 for the sine.
    // ---------------------------------------------------------------
    logic signed [2*COS_W-1:0] cos_sq;
    logic [RAD_W-1:0]          rad_next;

    assign cos_sq   = a_cos_reg * a_cos_reg;
    assign rad_next = {1'b1, 32'b0} - cos_sq[RAD_W-1:0];

    logic             b_vld_reg;
    logic [RAD_W-1:0] b_rad_reg;
    sq_side_t         b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_rad_reg  <= rad_next;
            b_side_reg <= '{cos_v: a_cos_reg, diff: a_diff_reg, trans: a_trans_reg};
        end
    end

    // ---------------------------------------------------------------
    // Sine by square root, then angle by CORDIC.
    // ---------------------------------------------------------------
    logic                 sq_vld;
    logic [SIN_W-1:0]     sq_sin;
    logic [SQ_SIDE_W-1:0] sq_side_bits;
    sq_side_t             sq_side;

    pmr_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_vld_reg),
        .in_rad    (b_rad_reg),
        .in_side   (b_side_reg),
        .out_valid (sq_vld),
        .out_root  (sq_sin),
        .out_side  (sq_side_bits)
    );

    assign sq_side = sq_side_bits;

    cd_side_t             cd_in_side;
    logic                 cd_vld;
    logic [ANG_W-1:0]     cd_angle;
    logic [CD_SIDE_W-1:0] cd_side_bits;
    cd_side_t             cd_side;

    assign cd_in_side = '{sin_v: sq_sin, diff: sq_side.diff, trans: sq_side.trans};

    pmr_cordic #(
        .SIDE_W (CD_SIDE_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_vld),
        .in_cos    (sq_side.cos_v),
        .in_sin    (sq_sin),
        .in_side   (cd_in_side),
        .out_valid (cd_vld),
        .out_angle (cd_angle),
        .out_side  (cd_side_bits)
    );

    assign cd_side = cd_side_bits;

    // ---------------------------------------------------------------
    // Stage E: compare the angle with the limit.
    // ---------------------------------------------------------------
    logic                          e_vld_reg;
    logic [ANG_W-1:0]              e_angle_reg;
    logic                          e_small_reg;
    logic [SIN_W-1:0]              e_sin_reg;
    logic [LANES-1:0][DIFF_W-1:0]  e_diff_reg;
    logic [LANES-1:0][TRANS_W-1:0] e_trans_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= cd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_angle_reg <= cd_angle;
            e_small_reg <= (cd_angle <= limit_reg);
            e_sin_reg   <= cd_side.sin_v;
            e_diff_reg  <= cd_side.diff;
            e_trans_reg <= cd_side.trans;
        end
    end

    // ---------------------------------------------------------------
    // Stage F: numerators angle * |d| and divisor 2 * sine.
    // ---------------------------------------------------------------
    logic [LANES-1:0][NUM_W-1:0] num_next;
    logic [LANES-1:0]            neg_next;
    logic [LANES-1:0]            zero_next;

    for (genvar l = 0; l < LANES; l++) begin : g_num
        logic signed [DIFF_W-1:0] diff_s;
        logic [DIFF_W-1:0]        diff_abs;

        assign diff_s       = e_diff_reg[l];
        assign neg_next[l]  = diff_s < 0;
        assign zero_next[l] = (diff_s == 0);
        assign diff_abs     = neg_next[l] ? DIFF_W'(-diff_s) : DIFF_W'(diff_s);
        assign num_next[l]  = NUM_W'(e_angle_reg * diff_abs[MAG_W-1:0]);
    end

    logic                        f_vld_reg;
    logic [LANES-1:0][NUM_W-1:0] f_num_reg;
    logic [DEN_W-1:0]            f_den_reg;
    dv_side_t                    f_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_num_reg  <= num_next;
            f_den_reg  <= {e_sin_reg, 1'b0};
            f_side_reg <= '{small_v: e_small_reg, sin_zero: (e_sin_reg == '0),
                            neg: neg_next, zero: zero_next, trans: e_trans_reg};
        end
    end

    // ---------------------------------------------------------------
    // Division, then sign and saturation into the output register.
    // ---------------------------------------------------------------
    logic                        dv_vld;
    logic [LANES-1:0][NUM_W-1:0] dv_quot;
    logic [DV_SIDE_W-1:0]        dv_side_bits;
    dv_side_t                    dv_side;

    pmr_div #(
        .SIDE_W (DV_SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_vld_reg),
        .in_num    (f_num_reg),
        .in_den    (f_den_reg),
        .in_side   (f_side_reg),
        .out_valid (dv_vld),
        .out_quot  (dv_quot),
        .out_side  (dv_side_bits)
    );

    assign dv_side = dv_side_bits;

    logic [LANES-1:0][OUT_W-1:0] rvec_next;

    for (genvar l = 0; l < LANES; l++) begin : g_out
        logic over;

        assign over = |dv_quot[l][NUM_W-1:OUT_W-1];

        always_comb
        begin
            if (dv_side.small_v)
            begin
                rvec_next[l] = '0;
            end
            else if (dv_side.sin_zero)
            begin
                // Angle at pi: the result goes to the rail that matches d.
                if (dv_side.zero[l])
                begin
                    rvec_next[l] = '0;
                end
                else if (dv_side.neg[l])
                begin
                    rvec_next[l] = {1'b1, {(OUT_W-1){1'b0}}};
                end
                else
                begin
                    rvec_next[l] = {1'b0, {(OUT_W-1){1'b1}}};
                end
            end
            else if (dv_side.neg[l])
            begin
                rvec_next[l] = over ? {1'b1, {(OUT_W-1){1'b0}}}
                                    : OUT_W'(-dv_quot[l][OUT_W-1:0]);
            end
            else
            begin
                rvec_next[l] = over ? {1'b0, {(OUT_W-1){1'b1}}}
                                    : {1'b0, dv_quot[l][OUT_W-2:0]};
            end
        end
    end

    logic                          out_vld_reg;
    logic [LANES-1:0][OUT_W-1:0]   out_rvec_reg;
    logic [LANES-1:0][TRANS_W-1:0] out_pos_reg;
    logic                          out_small_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rvec_reg  <= rvec_next;
            out_pos_reg   <= dv_side.trans;
            out_small_reg <= dv_side.small_v;
        end
    end

    assign vec_valid   = out_vld_reg;
    assign pos_x       = out_pos_reg[0];
    assign pos_y       = out_pos_reg[1];
    assign pos_z       = out_pos_reg[2];
    assign rvec_x      = out_rvec_reg[0];
    assign rvec_y      = out_rvec_reg[1];
    assign rvec_z      = out_rvec_reg[2];
    assign small_angle = out_small_reg;

endmodule

>>> bench/testbench.sv
// Self-checking bench for the pose matrix to position and rotation vector block.
// Depends on pmr_pkg, pose_matrix_to_position_rotvec and the units it uses.
// A directed table of pose words runs first, then random words under random idling.
`timescale 1ns / 100ps

module testbench;
    import pmr_pkg::*;

    // Register index on the configuration port.
    localparam int REG_LIMIT = 0;
    // Cycles from acceptance to output, with margin.
    localparam int DEPTH     = 80;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 1150;

    logic clk;
    logic rst_n;

    // Stimulus side.
    logic                      pose_valid;
    logic                      pose_stall;
    logic signed [ROT_W-1:0]   rot [9];
    logic signed [TRANS_W-1:0] trans [3];

    // Result side.
    logic                    vec_valid;
    logic                    vec_stall;
    logic signed [OUT_W-1:0] pos_x, pos_y, pos_z;
    logic signed [OUT_W-1:0] rvec_x, rvec_y, rvec_z;
    logic                    small_angle;

    // Configuration port.
    logic                  psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // One pose word as offered to the block.
    typedef struct {
        logic signed [ROT_W-1:0]   m [9];
        logic signed [TRANS_W-1:0] t [3];
    } pose_t;

    // One result word, either expected or observed.
    typedef struct {
        logic signed [OUT_W-1:0] p [3];
        logic signed [OUT_W-1:0] v [3];
        logic                    flag;
    } vec_t;

    // A directed row: the pose, a limit to load first (or -1 to keep), and an
    // optional hand-written expectation.
    typedef struct {
        pose_t pose;
        int    new_limit;
        bit    has_fixed;
        vec_t  fixed;
    } row_t;

    vec_t     expected_vecs [$];
    bit       mismatch;
    int       idle_cycles;
    bit       stim_done;
    bit       long_hold;
    logic [LIMIT_W-1:0] limit_shadow;

    pose_t  rnd_pose;
    row_t   rows [$];
    row_t   one_row;

    pose_matrix_to_position_rotvec u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pose_valid  (pose_valid),
        .pose_stall  (pose_stall),
        .rot_00      (rot[0]),
        .rot_01      (rot[1]),
        .rot_02      (rot[2]),
        .rot_10      (rot[3]),
        .rot_11      (rot[4]),
        .rot_12      (rot[5]),
        .rot_20      (rot[6]),
        .rot_21      (rot[7]),
        .rot_22      (rot[8]),
        .trans_x     (trans[0]),
        .trans_y     (trans[1]),
        .trans_z     (trans[2]),
        .vec_valid   (vec_valid),
        .vec_stall   (vec_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .rvec_x      (rvec_x),
        .rvec_y      (rvec_y),
        .rvec_z      (rvec_z),
        .small_angle (small_angle),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Arithmetic shift right with floor, on wide signed values.
    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    // Floor square root by the bitwise method.
    function automatic longint floor_root(longint n);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Angle of (c, s) by CORDIC vectoring, clamped to [0, pi].
    function automatic longint cordic_angle(longint c, longint s);
        longint x, y, z, nx, ny;
        if (c < 0)
        begin
            x = s <<< CORDIC_SHIFT;
            y = (-c) <<< CORDIC_SHIFT;
            z = HALF_PI_Q;
        end
        else
        begin
            x = c <<< CORDIC_SHIFT;
            y = s <<< CORDIC_SHIFT;
            z = 0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + shift_floor(y, i);
                ny = y - shift_floor(x, i);
                z  = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                nx = x - shift_floor(y, i);
                ny = y + shift_floor(x, i);
                z  = z - longint'(ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
            z = 0;
        if (z > PI_Q)
            z = PI_Q;
        return z;
    endfunction

    // One rotation vector component: theta * d / (2 s), truncated, saturated.
    // At zero sine the sign of d alone picks the rail.
    function automatic logic signed [OUT_W-1:0] rotvec_component(longint theta,
                                                                  longint d,
                                                                  longint s);
        longint q;
        bit     neg;
        if (s == 0)
        begin
            if (d > 0)
                return 32'sh7FFF_FFFF;
            if (d < 0)
                return 32'sh8000_0000;
            return '0;
        end
        neg = d < 0;
        q = (theta * (neg ? -d : d)) / (2 * s);
        if (q > 64'sh7FFF_FFFF && !neg)
            return 32'sh7FFF_FFFF;
        if (q > 64'sh8000_0000 && neg)
            return 32'sh8000_0000;
        return neg ? OUT_W'(-q) : OUT_W'(q);
    endfunction

    // Log map of one pose under the current limit.
    function automatic vec_t log_map(pose_t p, logic [LIMIT_W-1:0] lim);
        vec_t   r;
        longint tr, c, s, th;
        longint d [3];
        for (int k = 0; k < 3; k++)
            r.p[k] = p.t[k];
        tr = longint'(p.m[0]) + longint'(p.m[4]) + longint'(p.m[8]);
        c = (tr - Q_ONE) >>> 1;
        if (c > Q_ONE)
            c = Q_ONE;
        if (c < -Q_ONE)
            c = -Q_ONE;
        s  = floor_root((longint'(1) << 32) - c * c);
        th = cordic_angle(c, s);
        if (th <= longint'(lim))
        begin
            for (int k = 0; k < 3; k++)
                r.v[k] = '0;
            r.flag = 1'b1;
            return r;
        end
        d[0] = longint'(p.m[7]) - longint'(p.m[5]);
        d[1] = longint'(p.m[2]) - longint'(p.m[6]);
        d[2] = longint'(p.m[3]) - longint'(p.m[1]);
        for (int k = 0; k < 3; k++)
            r.v[k] = rotvec_component(th, d[k], s);
        r.flag = 1'b0;
        return r;
    endfunction

    // Random rotation element: mostly in range, with edges, sometimes any code.
    function automatic logic signed [ROT_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0:       return 18'sd65536;
            1:       return -18'sd65536;
            2:       return ROT_W'($urandom);
            default: return ROT_W'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // Random pose. Many are near-identity or near-pi so both the small-angle
    // branch and the saturating branch get plenty of traffic.
    function automatic pose_t random_pose();
        pose_t p;
        int    kind;
        kind = $urandom_range(0, 3);
        for (int k = 0; k < 9; k++)
            p.m[k] = random_element();
        if (kind == 0)
        begin
            // Trace close to three: tiny angles around the limit.
            p.m[0] = 18'sd65536 - ROT_W'($urandom_range(0, 40));
            p.m[4] = 18'sd65536 - ROT_W'($urandom_range(0, 40));
            p.m[8] = 18'sd65536 - ROT_W'($urandom_range(0, 40));
        end
        else if (kind == 1)
        begin
            // Trace close to minus one: angles near pi, sine near zero.
            p.m[0] = -18'sd65536 + ROT_W'($urandom_range(0, 30));
            p.m[4] = -18'sd65536 + ROT_W'($urandom_range(0, 30));
            p.m[8] = 18'sd65536 - ROT_W'($urandom_range(0, 30));
        end
        for (int k = 0; k < 3; k++)
            p.t[k] = $urandom;
        return p;
    endfunction

    // Register write: setup cycle then access cycle, only while idle.
    task automatic write_limit(logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(REG_LIMIT * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_shadow = value[LIMIT_W-1:0];
    endtask

    // Waits until every expected word has come back, then lets the pipeline
    // drain a full depth before the next register write.
    task automatic drain();
        while (expected_vecs.size() != 0)
            @(posedge clk);
        repeat (DEPTH) @(posedge clk);
    endtask

    // Offers one word, holding it until accepted, with a random gap before.
    task automatic send_pose(pose_t p);
        vec_t e;
        int   gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                          : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            pose_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pose_valid <= 1'b1;
        rot        <= p.m;
        trans      <= p.t;
        e = log_map(p, limit_shadow);
        do
            @(posedge clk);
        while (pose_stall);
        expected_vecs.insert(expected_vecs.size(), e);
    endtask

    // Adds a directed row. The fixed expectation is used where given.
    task automatic add_row(logic signed [ROT_W-1:0] m0, m1, m2, m3, m4, m5,
                           m6, m7, m8, int lim, bit fixed, int f,
                           logic signed [OUT_W-1:0] v0, v1, v2);
        one_row.pose.m    = '{m0, m1, m2, m3, m4, m5, m6, m7, m8};
        one_row.pose.t    = '{$urandom, $urandom, $urandom};
        one_row.new_limit = lim;
        one_row.has_fixed = fixed;
        one_row.fixed.p   = one_row.pose.t;
        one_row.fixed.v   = '{v0, v1, v2};
        one_row.fixed.flag = f[0];
        rows.insert(rows.size(), one_row);
    endtask

    // Receiver: random stall, plus one long hold-off while the sender keeps going.
    initial
    begin
        vec_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                vec_stall <= 1'b1;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            case ($urandom_range(0, 19))
                0:       vec_stall <= 1'b1;
                1:       begin
                             vec_stall <= 1'b1;
                             repeat ($urandom_range(5, 40)) @(posedge clk);
                         end
                2, 3:    vec_stall <= 1'b1;
                default: vec_stall <= 1'b0;
            endcase
        end
    end

    // Result checker: compares each accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        vec_t e;
        if (rst_n && vec_valid && !vec_stall)
        begin
            if (expected_vecs.size() == 0)
            begin
                $error("result word with nothing expected");
                mismatch = 1'b1;
            end
            else
            begin
                e = expected_vecs.pop_front();
                if (pos_x !== e.p[0])
                begin
                    $error("pos_x expected %0d got %0d", e.p[0], pos_x);
                    mismatch = 1'b1;
                end
                if (pos_y !== e.p[1])
                begin
                    $error("pos_y expected %0d got %0d", e.p[1], pos_y);
                    mismatch = 1'b1;
                end
                if (pos_z !== e.p[2])
                begin
                    $error("pos_z expected %0d got %0d", e.p[2], pos_z);
                    mismatch = 1'b1;
                end
                if (rvec_x !== e.v[0])
                begin
                    $error("rvec_x expected %0d got %0d", e.v[0], rvec_x);
                    mismatch = 1'b1;
                end
                if (rvec_y !== e.v[1])
                begin
                    $error("rvec_y expected %0d got %0d", e.v[1], rvec_y);
                    mismatch = 1'b1;
                end
                if (rvec_z !== e.v[2])
                begin
                    $error("rvec_z expected %0d got %0d", e.v[2], rvec_z);
                    mismatch = 1'b1;
                end
                if (small_angle !== e.flag)
                begin
                    $error("small_angle expected %0d got %0d", e.flag, small_angle);
                    mismatch = 1'b1;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side accepts a word.
    always @(posedge clk)
    begin
        if ((pose_valid && !pose_stall) || (vec_valid && !vec_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !stim_done)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random words under several limits.
    initial
    begin
        mismatch     = 1'b0;
        stim_done    = 1'b0;
        long_hold    = 1'b0;
        idle_cycles  = 0;
        limit_shadow = LIMIT_RESET;
        rst_n        = 1'b0;
        pose_valid   = 1'b0;
        rot          = '{default: '0};
        trans        = '{default: '0};
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity after reset: zero angle, flag raised.
        add_row(18'sd65536, 0, 0, 0, 18'sd65536, 0, 0, 0, 18'sd65536,
                -1, 1, 1, 0, 0, 0);
        // Trace beyond three: the argument clamps to one.
        add_row(18'sd131071, 0, 0, 0, 18'sd131071, 0, 0, 0, 18'sd131071,
                -1, 1, 1, 0, 0, 0);
        // Rotation by pi about z: sine is zero, differences all zero.
        add_row(-18'sd65536, 0, 0, 0, -18'sd65536, 0, 0, 0, 18'sd65536,
                -1, 1, 0, 0, 0, 0);
        // Angle at pi with nonzero differences: components go to the rails.
        add_row(-18'sd65536, -18'sd100, 18'sd100, 18'sd100, -18'sd65536,
                -18'sd100, -18'sd100, 18'sd100, 18'sd65536,
                -1, 1, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        // Trace far below minus one: the argument clamps to minus one.
        add_row(-18'sd131072, 18'sd1000, -18'sd1000, -18'sd1000,
                -18'sd131072, 18'sd1000, 18'sd1000, -18'sd1000,
                -18'sd131072, -1, 1, 0,
                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        // Quarter turn about z and about x, checked by the predictor.
        add_row(0, -18'sd65536, 0, 18'sd65536, 0, 0, 0, 0, 18'sd65536,
                -1, 0, 0, 0, 0, 0);
        add_row(18'sd65536, 0, 0, 0, 0, -18'sd65536, 0, 18'sd65536, 0,
                -1, 0, 0, 0, 0, 0);
        // Extremes of the element codes.
        add_row(18'sh1FFFF, 18'sh20000, 18'sh1FFFF, 18'sh20000, 18'sh1FFFF,
                18'sh20000, 18'sh1FFFF, 18'sh20000, 18'sh1FFFF,
                -1, 0, 0, 0, 0, 0);
        add_row(18'sh20000, 18'sh1FFFF, 18'sh20000, 18'sh1FFFF, 18'sh20000,
                18'sh1FFFF, 18'sh20000, 18'sh1FFFF, 18'sh20000,
                -1, 0, 0, 0, 0, 0);
        // Tiny angle just above a zero limit: large rotation/sine ratio.
        add_row(18'sd65535, 18'sd5, -18'sd7, -18'sd5, 18'sd65536, 18'sd9,
                18'sd7, -18'sd9, 18'sd65536, 0, 0, 0, 0, 0, 0);
        add_row(18'sd65536, 0, 0, 0, 18'sd65536, 0, 0, 0, 18'sd65536,
                -1, 0, 0, 0, 0, 0);
        // Limit at pi: small angle is forced even for a half turn.
        add_row(-18'sd65536, 18'sd50, 0, 0, -18'sd65536, 0, 0, 0, 18'sd65536,
                PI_Q, 1, 1, 0, 0, 0);
        // Largest register code, then back to the reset value.
        add_row(0, -18'sd65536, 0, 18'sd65536, 0, 0, 0, 0, 18'sd65536,
                (1 << LIMIT_W) - 1, 1, 1, 0, 0, 0);
        add_row(0, -18'sd65536, 0, 18'sd65536, 0, 0, 0, 0, 18'sd65536,
                66, 0, 0, 0, 0, 0);

        foreach (rows[i])
        begin
            if (rows[i].new_limit >= 0)
            begin
                pose_valid <= 1'b0;
                drain();
                write_limit(APB_DATA_W'(rows[i].new_limit));
            end
            send_pose(rows[i].pose);
            if (rows[i].has_fixed)
                expected_vecs[expected_vecs.size() - 1] = rows[i].fixed;
        end

        // Random words in phases, each under its own limit.
        for (int ph = 0; ph < 5; ph++)
        begin
            pose_valid <= 1'b0;
            drain();
            case (ph)
                0:       write_limit(APB_DATA_W'(LIMIT_RESET));
                1:       write_limit('0);
                2:       write_limit(APB_DATA_W'($urandom_range(0, PI_Q)));
                3:       write_limit(APB_DATA_W'(PI_Q - 1));
                default: write_limit(APB_DATA_W'($urandom_range(30, 2000)));
            endcase
            if (ph == 2)
                long_hold = 1'b1;
            for (int n = 0; n < N_RANDOM / 5; n++)
            begin
                rnd_pose = random_pose();
                send_pose(rnd_pose);
            end
        end
        pose_valid <= 1'b0;

        // Wait for everything to come back, bounded by the watchdog.
        while (expected_vecs.size() != 0 && idle_cycles <= WATCHDOG)
            @(posedge clk);
        stim_done = 1'b1;
        if (expected_vecs.size() != 0)
        begin
            $error("%0d result words never arrived", expected_vecs.size());
            mismatch = 1'b1;
        end
        repeat (DEPTH) @(posedge clk);

        if (!mismatch)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
sv/pmr_pkg.sv
sv/pmr_isqrt.sv
sv/pmr_cordic.sv
sv/pmr_div.sv
sv/pose_matrix_to_position_rotvec.sv
bench/testbench.sv
